FILE: rtl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg: shared constants and types of the square-root / CRC accelerator
// Word widths, iteration counts and the status bundle that each iterative
// unit reports to the bus-side sequencer.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Width of the bus registers.
  localparam int REG_W      = 32;
  // Operand width of both units.
  localparam int WORD_WIDTH = 32;
  localparam int ROOT_BITS  = (WORD_WIDTH + 1) / 2;
  localparam int RAD_W      = 2 * ROOT_BITS;
  localparam int REM_W      = ROOT_BITS + 2;
  localparam int SQ_CNT_W   = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
  localparam int CRC_CNT_W  = $clog2(WORD_WIDTH);

  localparam logic [REG_W-1:0] POLY_RESET = 32'hEDB88320;

  // Bus access kinds and register indexes.
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic REG_SQRT   = 1'b0;
  localparam logic REG_CRC    = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/sqrt_crc_accelerator_regs.sv
// ----------------------------------------------------------------------------
// sqrt_crc_accelerator_regs: square-root and CRC-32 bus accelerator
// Bus-side sequencer, result registers and polynomial register around the
// two iterative units.
// ----------------------------------------------------------------------------
// A beat is taken when start_i is high and busy_o is low, and its answer
// appears on read_data_o for exactly one cycle with done_o high; the receiver
// cannot stall it. A read answers in the cycle after the beat and leaves the
// block ready at once. A write to the square-root register runs the
// compare-subtract unit once per root bit, and a write to the CRC register runs
// one shift step per operand bit; busy_o stays high while the unit runs and in
// its finishing cycle, and the zero answer follows once busy_o falls.
// The user must write the polynomial through crc_polynomial_we_i only while
// the block is idle; the block itself does not enforce this.
module sqrt_crc_accelerator_regs
  import scr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             mode_i,
  input  logic             reg_index_i,
  input  logic [REG_W-1:0] write_data_i,
  output logic             done_o,
  output logic [REG_W-1:0] read_data_o,
  input  logic             crc_polynomial_we_i,
  input  logic [REG_W-1:0] crc_polynomial_i
);

  logic [REG_W-1:0]      poly_q;
  logic [ROOT_BITS-1:0]  root_result_q;
  logic [REG_W-1:0]      crc_result_q;
  logic                  done_q;
  logic [REG_W-1:0]      read_data_q;

  unit_stat_t            sqrt_stat;
  unit_stat_t            crc_stat;
  logic [ROOT_BITS-1:0]  root_res;
  logic [WORD_WIDTH-1:0] crc_res;

  logic                  accept;
  logic                  rd_beat;
  logic                  sqrt_start;
  logic                  crc_start;
  logic [REG_W-1:0]      rd_sel;

  // The finishing cycle of a unit counts as busy so that its answer never
  // collides with the answer to a read.
  assign busy_o     = sqrt_stat.busy | sqrt_stat.done | crc_stat.busy | crc_stat.done;
  assign accept     = start_i & ~busy_o;
  assign rd_beat    = accept & (mode_i == MODE_READ);
  assign sqrt_start = accept & (mode_i == MODE_WRITE) & (reg_index_i == REG_SQRT);
  assign crc_start  = accept & (mode_i == MODE_WRITE) & (reg_index_i == REG_CRC);
  assign rd_sel     = (reg_index_i == REG_CRC) ? crc_result_q : REG_W'(root_result_q);

  scr_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .operand_i (WORD_WIDTH'(write_data_i)),
    .stat_o    (sqrt_stat),
    .root_o    (root_res)
  );

  scr_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crc_start),
    .data_i  (WORD_WIDTH'(write_data_i)),
    .poly_i  (WORD_WIDTH'(poly_q)),
    .stat_o  (crc_stat),
    .crc_o   (crc_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q        <= POLY_RESET;
      root_result_q <= '0;
      crc_result_q  <= '0;
      done_q        <= 1'b0;
    end else begin
      if (crc_polynomial_we_i) begin
        poly_q <= crc_polynomial_i;
      end
      if (sqrt_stat.done) begin
        root_result_q <= root_res;
      end
      if (crc_stat.done) begin
        crc_result_q <= REG_W'(crc_res);
      end
      done_q <= rd_beat | sqrt_stat.done | crc_stat.done;
    end
  end

  always_ff @(posedge clk_i) begin
    read_data_q <= rd_beat ? rd_sel : '0;
  end

  assign done_o      = done_q;
  assign read_data_o = read_data_q;

  ap_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == MODE_WRITE) |=> busy_o)
    else $error("write beat did not make the block busy");

  ap_one_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sqrt_stat.busy && crc_stat.busy))
    else $error("both units running at once");

  ap_write_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sqrt_stat.done || crc_stat.done) |=> (done_o && read_data_o == '0))
    else $error("write answer missing or nonzero");

  ap_read_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_beat |=> done_o)
    else $error("read beat got no answer");

endmodule

FILE: rtl/scr_sqrt.sv
// ----------------------------------------------------------------------------
// scr_sqrt: iterative floor square root
// Digit-by-digit root: each cycle brings in two radicand bits and resolves
// one root bit with a single compare and subtract.
// ----------------------------------------------------------------------------
module scr_sqrt
  import scr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_WIDTH-1:0] operand_i,
  output unit_stat_t           stat_o,
  output logic [ROOT_BITS-1:0] root_o
);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [SQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic [RAD_W-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [ROOT_BITS-1:0] root_q, root_d;

  logic [REM_W+1:0]     rem_sh;
  logic [REM_W+1:0]     trial;
  logic                 fits;
  logic                 last;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_q, 2'b01});
  assign fits   = rem_sh >= trial;
  assign last   = cnt_q == SQ_CNT_W'(ROOT_BITS - 1);

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rad_d  = RAD_W'(operand_i);
      rem_d  = '0;
      root_d = '0;
    end else if (run_q) begin
      rad_d  = rad_q << 2;
      rem_d  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_d = {root_q[ROOT_BITS-2:0], fits};
      cnt_d  = cnt_q + SQ_CNT_W'(1);
      if (last) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

FILE: rtl/scr_crc.sv
// ----------------------------------------------------------------------------
// scr_crc: iterative reflected CRC of one word
// The register starts at all ones xor the data, takes one right shift per
// cycle with the polynomial xored in on a shifted-out one, and is inverted.
// ----------------------------------------------------------------------------
module scr_crc
  import scr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [WORD_WIDTH-1:0] data_i,
  input  logic [WORD_WIDTH-1:0] poly_i,
  output unit_stat_t            stat_o,
  output logic [WORD_WIDTH-1:0] crc_o
);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [CRC_CNT_W-1:0]  cnt_q, cnt_d;
  logic [WORD_WIDTH-1:0] crc_q, crc_d;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      crc_d = ~data_i;
    end else if (run_q) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ poly_i) : (crc_q >> 1);
      cnt_d = cnt_q + CRC_CNT_W'(1);
      if (cnt_q == CRC_CNT_W'(WORD_WIDTH - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign crc_o       = ~crc_q;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: bus-level test of the square-root / CRC-32 accelerator
// Drives read and write beats on the command port and predicts every answer
// from an in-bench copy of both result registers and the polynomial. The run
// steps the polynomial through several values, including the extremes.
// ----------------------------------------------------------------------------
module tb;
  import scr_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 108;

  class sqrt_crc_scoreboard;
    logic [REG_W-1:0]     poly;
    logic [ROOT_BITS-1:0] root_reg;
    logic [REG_W-1:0]     crc_reg;
    logic [REG_W-1:0]     answers_due[$];
    int                   errors;

    function new();
      poly     = POLY_RESET;
      root_reg = '0;
      crc_reg  = '0;
      errors   = 0;
    endfunction

    function logic [ROOT_BITS-1:0] floor_root(logic [WORD_WIDTH-1:0] n);
      logic [ROOT_BITS-1:0] root;
      logic [ROOT_BITS-1:0] trial;
      root = '0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
        trial = root | (ROOT_BITS'(1) << b);
        if (64'(trial) * 64'(trial) <= 64'(n)) root = trial;
      end
      return root;
    endfunction

    function logic [WORD_WIDTH-1:0] word_crc(logic [WORD_WIDTH-1:0] d);
      logic [WORD_WIDTH-1:0] c;
      c = {WORD_WIDTH{1'b1}} ^ d;
      for (int i = 0; i < WORD_WIDTH; i++) begin
        if (c[0]) c = (c >> 1) ^ poly[WORD_WIDTH-1:0];
        else c = c >> 1;
      end
      return ~c;
    endfunction

    function void note_access(logic mode, logic sel, logic [REG_W-1:0] data);
      if (mode == MODE_WRITE) begin
        if (sel == REG_CRC) crc_reg = REG_W'(word_crc(data[WORD_WIDTH-1:0]));
        else root_reg = floor_root(data[WORD_WIDTH-1:0]);
        answers_due.push_back('0);
      end else begin
        answers_due.push_back((sel == REG_CRC) ? crc_reg : REG_W'(root_reg));
      end
    endfunction

    function void check_answer(logic [REG_W-1:0] got);
      logic [REG_W-1:0] want;
      if (answers_due.size() == 0) begin
        $error("read_data: no access pending, got %h", got);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          $error("read_data: expected %h, got %h", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  logic             clk_i               = 1'b0;
  logic             rst_ni              = 1'b0;
  logic             start_i             = 1'b0;
  logic             mode_i              = MODE_READ;
  logic             reg_index_i         = REG_SQRT;
  logic [REG_W-1:0] write_data_i        = '0;
  logic             crc_polynomial_we_i = 1'b0;
  logic [REG_W-1:0] crc_polynomial_i    = '0;
  logic             busy_o;
  logic             done_o;
  logic [REG_W-1:0] read_data_o;

  sqrt_crc_scoreboard sb;
  int quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  sqrt_crc_accelerator_regs DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .mode_i              (mode_i),
    .reg_index_i         (reg_index_i),
    .write_data_i        (write_data_i),
    .done_o              (done_o),
    .read_data_o         (read_data_o),
    .crc_polynomial_we_i (crc_polynomial_we_i),
    .crc_polynomial_i    (crc_polynomial_i)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_access(mode_i, reg_index_i, write_data_i);
      if (done_o) sb.check_answer(read_data_o);
      if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Start stays high after a beat is taken, so back-to-back beats need no gap.
  task automatic issue(input logic mode, input logic sel, input logic [REG_W-1:0] data);
    start_i      <= 1'b1;
    mode_i       <= mode;
    reg_index_i  <= sel;
    write_data_i <= data;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic pause(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // The first edge lets the monitor record a beat taken at the current edge.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_poly(input logic [REG_W-1:0] p);
    crc_polynomial_we_i <= 1'b1;
    crc_polynomial_i    <= p;
    @(posedge clk_i);
    crc_polynomial_we_i <= 1'b0;
    crc_polynomial_i    <= $urandom();
    sb.poly = p;
  endtask

  task automatic random_access(output logic mode, output logic sel,
                               output logic [REG_W-1:0] data);
    logic [15:0] k;
    mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
    sel  = $urandom_range(0, 1) ? REG_CRC : REG_SQRT;
    k    = 16'($urandom());
    case ($urandom_range(0, 5))
      0: data = $urandom_range(0, 255);
      1: data = 32'(k) * 32'(k);
      2: data = 32'(k) * 32'(k) - 32'd1;
      3: data = $urandom_range(0, 1) ? '1 : '0;
      4: data = 32'(k);
      default: data = $urandom();
    endcase
  endtask

  initial begin
    logic             mode;
    logic             sel;
    logic [REG_W-1:0] data;
    logic [REG_W-1:0] poly_plan[PHASES];

    sb = new();
    poly_plan = '{POLY_RESET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h04C1_1DB7,
                  POLY_RESET};
    poly_plan[3] = $urandom();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both registers read as zero before anything is written.
    issue(MODE_READ, REG_SQRT, 32'hDEAD_BEEF);
    issue(MODE_READ, REG_CRC, 32'hFFFF_FFFF);
    issue(MODE_WRITE, REG_SQRT, 32'd0);
    issue(MODE_READ, REG_SQRT, '0);
    issue(MODE_WRITE, REG_SQRT, 32'd1);
    issue(MODE_READ, REG_SQRT, '0);
    issue(MODE_WRITE, REG_SQRT, 32'd3);
    issue(MODE_READ, REG_SQRT, '0);
    issue(MODE_WRITE, REG_SQRT, 32'd4);
    issue(MODE_READ, REG_SQRT, '0);
    issue(MODE_WRITE, REG_SQRT, 32'hFFFE_0000);
    issue(MODE_READ, REG_SQRT, '0);
    issue(MODE_WRITE, REG_SQRT, 32'hFFFE_0001);
    issue(MODE_READ, REG_SQRT, '0);
    issue(MODE_WRITE, REG_SQRT, 32'hFFFF_FFFF);
    issue(MODE_WRITE, REG_CRC, 32'h0000_0000);
    issue(MODE_READ, REG_CRC, '0);
    issue(MODE_WRITE, REG_CRC, 32'hFFFF_FFFF);
    issue(MODE_READ, REG_CRC, '0);
    issue(MODE_WRITE, REG_CRC, 32'h1234_5678);
    // A CRC write leaves the stored root alone, and the other way round.
    issue(MODE_READ, REG_SQRT, '1);
    issue(MODE_WRITE, REG_SQRT, 32'd2);
    issue(MODE_READ, REG_CRC, '0);
    issue(MODE_READ, REG_SQRT, '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        write_poly(poly_plan[ph]);
      end
      for (int i = 0; i < PHASE_BEATS; i++) begin
        random_access(mode, sel, data);
        issue(mode, sel, data);
        if (ph < PHASES - 1 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 11));
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/scr_pkg.sv
rtl/scr_sqrt.sv
rtl/scr_crc.sv
rtl/sqrt_crc_accelerator_regs.sv
sim/tb.sv
